>>> rtl/rsti_pkg.sv
// Shared types and constants for the radix string-to-integer unit.
package rsti_pkg;

    localparam int ALPHA_SYMS  = 16;
    localparam int ALPHA_BITS  = 8 * ALPHA_SYMS;
    localparam int BASE_BITS   = 5;
    localparam int DIGIT_BITS  = 4;
    localparam int CFG_BITS    = 64;
    localparam int ADDR_BITS   = 5;
    localparam int OUT_BITS    = 32;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [BASE_BITS-1:0] BASE_LEN_RESET = 5'd10;

    localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] REG_BASE_LEN   = 2'd2;

    typedef enum logic [3:0] {
        PH_SPACE = 4'b0001,
        PH_SIGN  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                  is_space;
        logic                  is_plus;
        logic                  is_minus;
        logic                  hit;
        logic [DIGIT_BITS-1:0] digit;
    } char_class_t;

    function automatic logic is_space_char(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

>>> rtl/rsti_match.sv
// Character classifier: whitespace, sign and digit lookup in the alphabet.
module rsti_match
    import rsti_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic [7:0]            ch,
    input  logic [ALPHA_BITS-1:0] alphabet,
    input  logic [BASE_BITS-1:0]  base_len,
    output char_class_t           cls
);

    always_comb begin
        cls          = '0;
        cls.is_space = is_space_char(ch);
        cls.is_plus  = (ch == CH_PLUS);
        cls.is_minus = (ch == CH_MINUS);
        // highest index first so the lowest matching symbol wins
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if ((BASE_BITS'(i) < base_len) && (alphabet[8*i +: 8] == ch)) begin
                cls.hit   = 1'b1;
                cls.digit = DIGIT_BITS'(i);
            end
        end
    end

endmodule

>>> rtl/rsti_alpha_check.sv
// Alphabet validity check: radix range, forbidden symbols, duplicates.
module rsti_alpha_check
    import rsti_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic [ALPHA_BITS-1:0] alphabet,
    input  logic [BASE_BITS-1:0]  base_len,
    output logic                  ok
);

    logic [7:0] sym_i;
    logic       bad;

    always_comb begin
        bad   = (base_len < BASE_BITS'(2)) || (base_len > BASE_BITS'(MAX_SYMBOLS));
        sym_i = '0;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            sym_i = alphabet[8*i +: 8];
            if (BASE_BITS'(i) < base_len) begin
                if ((sym_i == 8'h00) || (sym_i == CH_PLUS) || (sym_i == CH_MINUS) ||
                    is_space_char(sym_i)) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if ((BASE_BITS'(j) < base_len) && (alphabet[8*j +: 8] == sym_i)) begin
                        bad = 1'b1;
                    end
                end
            end
        end
        ok = !bad;
    end

endmodule

>>> rtl/radix_string_to_int_unit.sv
// Top level of the radix string-to-integer unit.
//
// Usage: characters arrive one per item on the s_ stream (s_tdata = ch,
// s_tlast marks the final character of a string). One result item leaves
// on the m_ stream per string: m_tdata = value, m_tuser = base_ok.
// The digit alphabet and radix are written over the APB port; the user
// must do so only while the unit is idle, which the block does not enforce
// (alphabet_low at 0x00, alphabet_high at 0x08, base_len at 0x10).
// Throughput: one character per cycle while results are not backed up behind
// a stalled receiver. The rate is set by the parser state update, one
// multiply-add of the accumulator by the radix. After the last character
// is accepted into the input register, the result passes through the result
// register, then the output register with sign fixup, to m_tvalid.
// Reset clears the parser, drops any queued items and restores the
// registers (empty alphabet, radix 10). When the receiver stalls, the
// waiting result holds; non-final characters keep flowing, and input
// backpressure starts only once a second finished result is queued behind it.
module radix_string_to_int_unit
    import rsti_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [CFG_BITS-1:0]  pwdata,
    output logic [CFG_BITS-1:0]  prdata,
    output logic                 pready,
    // characters
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] ch
    input  logic                 s_tlast,
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_BITS-1:0]  m_tdata,   // [31:0] value
    output logic                 m_tuser    // [0] base_ok
);

    localparam int PROD_BITS = VALUE_BITS + BASE_BITS;

    // configuration registers
    logic [CFG_BITS-1:0]  alpha_low_reg;
    logic [CFG_BITS-1:0]  alpha_high_reg;
    logic [BASE_BITS-1:0] base_len_reg;
    logic                 base_ok_reg;
    logic                 base_ok_next;
    logic                 cfg_wr;

    // input stage
    logic        a_valid_reg;
    char_class_t a_cls_reg;
    logic        a_last_reg;
    char_class_t cls_next;
    logic        a_go;

    // parser state
    phase_t                phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [PROD_BITS-1:0]  prod;
    logic [VALUE_BITS-1:0] acc_mac;

    // result stage (raw) and output stage
    logic                  r_valid_reg;
    logic [VALUE_BITS-1:0] r_acc_reg;
    logic                  r_neg_reg;
    logic                  r_ready;
    logic                  r_free;
    logic [VALUE_BITS-1:0] r_signed;

    logic                  o_valid_reg;
    logic [OUT_BITS-1:0]   o_value_reg;
    logic                  o_ok_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            base_len_reg   <= BASE_LEN_RESET;
            base_ok_reg    <= 1'b0;
        end else begin
            base_ok_reg <= base_ok_next;
            if (cfg_wr) begin
                case (paddr[4:3])
                    REG_ALPHA_LOW:  alpha_low_reg  <= pwdata;
                    REG_ALPHA_HIGH: alpha_high_reg <= pwdata;
                    REG_BASE_LEN:   base_len_reg   <= pwdata[BASE_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_ALPHA_LOW:  prdata = alpha_low_reg;
            REG_ALPHA_HIGH: prdata = alpha_high_reg;
            REG_BASE_LEN:   prdata = CFG_BITS'(base_len_reg);
            default:        prdata = '0;
        endcase
    end

    rsti_alpha_check #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_alpha_check (
        .alphabet ({alpha_high_reg, alpha_low_reg}),
        .base_len (base_len_reg),
        .ok       (base_ok_next)
    );

    // ---------------- input stage ----------------
    rsti_match #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_match (
        .ch       (s_tdata),
        .alphabet ({alpha_high_reg, alpha_low_reg}),
        .base_len (base_len_reg),
        .cls      (cls_next)
    );

    assign r_ready  = !o_valid_reg || m_tready;
    assign r_free   = !r_valid_reg || r_ready;
    assign a_go     = a_valid_reg && (!a_last_reg || r_free);
    assign s_tready = !a_valid_reg || a_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_cls_reg  <= cls_next;
            a_last_reg <= s_tlast;
        end
    end

    // ---------------- parser ----------------
    assign prod    = PROD_BITS'(acc_reg) * PROD_BITS'(base_len_reg);
    assign acc_mac = prod[VALUE_BITS-1:0] + VALUE_BITS'(a_cls_reg.digit);

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        case (phase_reg)
            PH_SPACE, PH_SIGN: begin
                if ((phase_reg == PH_SPACE) && a_cls_reg.is_space) begin
                    phase_next = PH_SPACE;
                end else if (a_cls_reg.is_plus || a_cls_reg.is_minus) begin
                    neg_next   = neg_reg ^ a_cls_reg.is_minus;
                    phase_next = PH_SIGN;
                end else if (a_cls_reg.hit) begin
                    acc_next   = acc_mac;
                    phase_next = PH_DIGIT;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_DIGIT: begin
                if (a_cls_reg.hit) begin
                    acc_next = acc_mac;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: phase_next = PH_DONE;
            default: phase_next = PH_DONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end else if (a_go) begin
            if (a_last_reg) begin
                phase_reg <= PH_SPACE;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
            end else begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
            end
        end
    end

    // ---------------- result and output stages ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (r_free) begin
            r_valid_reg <= a_go && a_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_free && a_go && a_last_reg) begin
            r_acc_reg <= acc_next;
            r_neg_reg <= neg_next;
        end
    end

    assign r_signed = r_neg_reg ? (VALUE_BITS'(0) - r_acc_reg) : r_acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (r_ready) begin
            o_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_ready && r_valid_reg) begin
            o_value_reg <= base_ok_reg ? OUT_BITS'(r_signed) : '0;
            o_ok_reg    <= base_ok_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_value_reg;
    assign m_tuser  = o_ok_reg;

`ifndef SYNTHESIS
    a_parser_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        a_go && a_last_reg |=> (phase_reg == PH_SPACE) && !neg_reg && (acc_reg == '0))
        else $error("parser not cleared after final character");

    a_result_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        a_go && a_last_reg |=> r_valid_reg)
        else $error("final character did not queue a result");

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == '0))
        else $error("invalid alphabet gave nonzero value");

    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");
`endif

endmodule

>>> test/radix_string_to_int_unit_test.sv
// Self-checking stream test of radix_string_to_int_unit against a built-in parser model.
`timescale 1ns / 1ps

module radix_string_to_int_unit_test;
    import rsti_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                base_ok;
    } parse_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_BITS-1:0] paddr    = '0;
    logic [CFG_BITS-1:0]  pwdata   = '0;
    logic [CFG_BITS-1:0]  prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;    // [7:0] ch
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_tdata;          // [31:0] value
    logic                 m_tuser;          // [0] base_ok

    // configuration copy and parser state of the model
    logic [63:0]          cfg_alpha_lo = '0;
    logic [63:0]          cfg_alpha_hi = '0;
    logic [BASE_BITS-1:0] cfg_radix    = BASE_LEN_RESET;
    phase_t               prs_phase    = PH_SPACE;
    logic                 prs_neg      = 1'b0;
    logic [OUT_BITS-1:0]  prs_acc      = '0;

    char_item_t    chars_to_send[$];
    parse_result_t values_due[$];
    char_item_t    next_char;
    logic [7:0]    sym_tab[ALPHA_SYMS];
    int            chars_sent  = 0;
    int            chars_taken = 0;
    int            mismatches  = 0;
    int            src_mode    = 0;
    int            src_span    = 0;
    int            src_hold    = 0;
    int            sink_mode   = 0;
    int            sink_span   = 0;
    int            sink_hold   = 0;

    radix_string_to_int_unit i_dut (.*);

    always #4 aclk = ~aclk;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] symbol_of(input int k);
        return k < 8 ? cfg_alpha_lo[8*k +: 8] : cfg_alpha_hi[8*(k-8) +: 8];
    endfunction

    function automatic logic alphabet_ok();
        logic [7:0] s;
        if (cfg_radix < 2 || cfg_radix > ALPHA_SYMS)
            return 1'b0;
        for (int i = 0; i < cfg_radix; i++) begin
            s = symbol_of(i);
            if (s == 8'h00 || s == CH_PLUS || s == CH_MINUS || is_blank(s))
                return 1'b0;
            for (int j = i + 1; j < cfg_radix; j++)
                if (symbol_of(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int digit_index(input logic [7:0] c);
        int n;
        n = cfg_radix > ALPHA_SYMS ? ALPHA_SYMS : int'(cfg_radix);
        for (int i = 0; i < n; i++)
            if (symbol_of(i) == c)
                return i;
        return -1;
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic last);
        int d;
        parse_result_t r;
        if (prs_phase == PH_SPACE && is_blank(c)) begin
            // leading blank, stay
        end else if ((prs_phase == PH_SPACE || prs_phase == PH_SIGN) &&
                     (c == CH_PLUS || c == CH_MINUS)) begin
            if (c == CH_MINUS)
                prs_neg = !prs_neg;
            prs_phase = PH_SIGN;
        end else if (prs_phase != PH_DONE) begin
            d = digit_index(c);
            if (d < 0) begin
                prs_phase = PH_DONE;
            end else begin
                prs_acc   = prs_acc * OUT_BITS'(cfg_radix) + OUT_BITS'(d);
                prs_phase = PH_DIGIT;
            end
        end
        if (last) begin
            r.base_ok = alphabet_ok();
            r.value   = !r.base_ok ? '0 : prs_neg ? -prs_acc : prs_acc;
            values_due.push_back(r);
            prs_phase = PH_SPACE;
            prs_neg   = 1'b0;
            prs_acc   = '0;
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
    endfunction

    function automatic void check_result(input logic [OUT_BITS-1:0] got_value,
                                         input logic got_ok);
        parse_result_t want;
        if (values_due.size() == 0) begin
            note_failure($sformatf("unexpected result value %0d base_ok %0b",
                                   $signed(got_value), got_ok));
            return;
        end
        want = values_due.pop_front();
        if (want.value !== got_value || want.base_ok !== got_ok)
            note_failure($sformatf("expected value %0d base_ok %0b, got value %0d base_ok %0b",
                                   $signed(want.value), want.base_ok,
                                   $signed(got_value), got_ok));
    endfunction

    function automatic int idle_len(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < (mode == 1 ? 85 : 50))
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // character source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata, s_tlast);
                chars_taken++;
                if (src_span == 0) begin
                    src_mode = $urandom_range(0, 2);
                    src_span = $urandom_range(20, 80);
                end else begin
                    src_span--;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (src_hold > 0) begin
                    src_hold--;
                    s_tvalid <= 1'b0;
                end else if (chars_to_send.size() != 0) begin
                    next_char = chars_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_char.ch;
                    s_tlast  <= next_char.last;
                    src_hold = idle_len(src_mode);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            if (sink_span == 0) begin
                sink_mode = $urandom_range(0, 2);
                sink_span = $urandom_range(30, 120);
            end else begin
                sink_span--;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_hold = idle_len(sink_mode);
            end
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ALPHA_LOW:  cfg_alpha_lo = val;
            REG_ALPHA_HIGH: cfg_alpha_hi = val;
            REG_BASE_LEN:   cfg_radix = val[BASE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic write_alphabet(input int radix);
        logic [63:0] lo, hi;
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = sym_tab[k];
            hi[8*k +: 8] = sym_tab[k + 8];
        end
        cfg_write(REG_ALPHA_LOW, lo);
        cfg_write(REG_ALPHA_HIGH, hi);
        cfg_write(REG_BASE_LEN, 64'(radix));
    endtask

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return r == 0 ? CH_SPACE : 8'(CH_TAB + r - 1);
    endfunction

    function automatic logic [7:0] bad_symbol();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return CH_PLUS;
            2: return CH_MINUS;
            default: return blank_char();
        endcase
    endfunction

    function automatic logic [7:0] some_digit();
        int n;
        n = cfg_radix > ALPHA_SYMS ? ALPHA_SYMS : int'(cfg_radix);
        if (n == 0)
            return 8'($urandom);
        return sym_tab[$urandom_range(0, n - 1)];
    endfunction

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 3))
            0: return blank_char();
            1: return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
            2: return some_digit();
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_char(input logic [7:0] c, input logic last);
        chars_to_send.push_back('{ch: c, last: last});
        chars_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    task automatic queue_string();
        logic [7:0] txt[$];
        int shape;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(1, 8))
                txt.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 3))
                txt.push_back(blank_char());
            repeat ($urandom_range(0, 3))
                txt.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if (shape == 1)
                txt.push_back(blank_char());
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(9, 14) : $urandom_range(0, 8))
                txt.push_back(some_digit());
            if (shape <= 3)
                repeat ($urandom_range(1, 4))
                    txt.push_back(any_char());
        end
        if (txt.size() == 0)
            txt.push_back(some_digit());
        foreach (txt[i])
            push_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic pick_alphabet();
        logic [7:0] b;
        logic fresh;
        int k, i, j, radix;
        k = 0;
        while (k < ALPHA_SYMS) begin
            b = 8'($urandom_range(1, 255));
            fresh = !(b == CH_PLUS || b == CH_MINUS || is_blank(b));
            for (j = 0; j < k; j++)
                if (sym_tab[j] == b)
                    fresh = 1'b0;
            if (fresh) begin
                sym_tab[k] = b;
                k++;
            end
        end
        case ($urandom_range(0, 9))
            0: radix = 2;
            1: radix = ALPHA_SYMS;
            default: radix = $urandom_range(2, ALPHA_SYMS);
        endcase
        case ($urandom_range(0, 11))
            0: begin
                i = $urandom_range(0, radix - 2);
                j = $urandom_range(i + 1, radix - 1);
                sym_tab[j] = sym_tab[i];
            end
            1: sym_tab[$urandom_range(0, radix - 1)] = bad_symbol();
            2: radix = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                            : $urandom_range(ALPHA_SYMS + 1, 31);
            3: for (j = radix; j < ALPHA_SYMS; j++)
                sym_tab[j] = 8'h00;
            4: begin
                for (j = 0; j < ALPHA_SYMS; j++)
                    sym_tab[j] = 8'hFF;
                radix = 31;
            end
            default: ;
        endcase
        write_alphabet(radix);
    endtask

    // all results in, then room for the pipeline to settle
    task automatic drain();
        while (chars_taken != chars_sent || values_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int target, start_count;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset alphabet is empty, so any string gives zero
        push_char(CH_SPACE, 1'b0);
        send_str("-7");
        drain();

        for (int k = 0; k < ALPHA_SYMS; k++)
            sym_tab[k] = k < 10 ? 8'("0" + k) : 8'("A" + k - 10);
        write_alphabet(ALPHA_SYMS);
        push_char(CH_CR, 1'b0);
        send_str("--1");
        push_char(CH_MINUS, 1'b0);
        push_char(CH_SPACE, 1'b0);
        send_str("5");
        send_str("1G2");
        push_char("3", 1'b0);
        push_char(8'h00, 1'b1);
        push_char(CH_PLUS, 1'b0);
        push_char(8'hFF, 1'b1);
        push_char(CH_TAB, 1'b0);
        send_str("-1FFFFFFFF");
        drain();

        start_count = chars_sent;
        while (chars_sent - start_count < 600) begin
            pick_alphabet();
            target = chars_sent + $urandom_range(30, 70);
            while (chars_sent < target)
                queue_string();
            drain();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && values_due.size() == 0)
            $display("radix_string_to_int_unit_test: PASS");
        else
            $display("radix_string_to_int_unit_test: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("radix_string_to_int_unit_test: FAIL");
        $finish;
    end

endmodule
